@@ hdl/shtc_pkg.sv @@
package shtc_pkg;

    localparam int HIT_W   = 16;
    localparam int TRACK_W = 12;
    localparam int EPOCH_W = 4;

    typedef struct packed {
        logic [HIT_W-1:0]   hit_index;
        logic [TRACK_W-1:0] track_id;
        logic               last_hit;
        logic               start_of_event;
    } t_in_beat;

    typedef struct packed {
        logic [TRACK_W-1:0] result_track;
        logic [TRACK_W-1:0] cluster_id;
        logic               new_cluster;
        logic               hits_overflow;
    } t_out_beat;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [TRACK_W-1:0] owner;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic look;
        logic check;
        logic wb_start;
        logic wb_run;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic soe_wrap;
        logic clear_last;
        logic last;
        logic match_now;
        logic wb_done;
        logic out_free;
    } t_status;

    // Remainder of a 16-bit value by a constant whose quotient stays below 256.
    function automatic logic [HIT_W-1:0] reduce(input logic [HIT_W-1:0] value,
                                               input int unsigned divisor);
        logic [31:0]      step;
        logic [HIT_W-1:0] rem;
        rem = value;
        for (int k = 7; k >= 0; k--) begin
            step = 32'(divisor) << k;
            if ({16'b0, rem} >= step) begin
                rem = rem - step[HIT_W-1:0];
            end
        end
        return rem;
    endfunction

endpackage

@@ hdl/shared_hit_track_clustering_top.sv @@
// Channel   Valid        Ready        Payload
// input     i_in_valid   o_in_ready   i_in  (shtc_pkg::t_in_beat)
// output    o_out_valid  i_out_ready  o_out (shtc_pkg::t_out_beat)
//
// Each hit beat is accepted with the owner-table read, then checked.
// The last hit of a track then goes on to emit; a track that opens a cluster first
// writes its buffered hits back through the table port.
// Reset starts a clearing pass over all HIT_SPACE table entries; every fifteenth
// start_of_event repeats it as the epoch mark wraps; no beat is taken in the pass.
// A held result stalls the emitting track, and no beat is taken while it waits.
module shared_hit_track_clustering_top #(
    parameter int HIT_SPACE          = 65536,
    parameter int MAX_TRACKS         = 4096,
    parameter int MAX_HITS_PER_TRACK = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  shtc_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output shtc_pkg::t_out_beat o_out
);

    shtc_pkg::t_cmd    cmd;
    shtc_pkg::t_status status;

    shtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    shtc_dp #(
        .HIT_SPACE          (HIT_SPACE),
        .MAX_TRACKS         (MAX_TRACKS),
        .MAX_HITS_PER_TRACK (MAX_HITS_PER_TRACK)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

@@ hdl/shtc_ctrl.sv @@
module shtc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  shtc_pkg::t_status i_status,
    output shtc_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_CHECK = 6'b001000,
        S_WB    = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_item;
    logic   n_item;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = r_item ? S_LOOK : S_IDLE;
                    n_item  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.soe_wrap) begin
                        n_state = S_CLEAR;
                        n_item  = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (i_status.match_now) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.wb_start = 1'b1;
                    n_state        = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb_run = 1'b1;
                if (i_status.wb_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_item  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_item  <= n_item;
        end
    end

endmodule

@@ hdl/shtc_dp.sv @@
module shtc_dp #(
    parameter int HIT_SPACE          = 65536,
    parameter int MAX_TRACKS         = 4096,
    parameter int MAX_HITS_PER_TRACK = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shtc_pkg::t_in_beat  i_in,
    input  shtc_pkg::t_cmd      i_cmd,
    output shtc_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output shtc_pkg::t_out_beat o_out
);

    localparam int HW = $clog2(HIT_SPACE);
    localparam int BW = $clog2(MAX_HITS_PER_TRACK);
    localparam int CW = BW + 1;
    localparam int TW = shtc_pkg::TRACK_W;
    localparam int EW = shtc_pkg::EPOCH_W;
    localparam int XW = shtc_pkg::HIT_W;

    shtc_pkg::t_entry r_tbl_mem [HIT_SPACE];
    logic [HW-1:0]    r_buf_mem [MAX_HITS_PER_TRACK];

    shtc_pkg::t_entry    r_tbl_q;
    logic [HW-1:0]       r_buf_q;
    logic [HW-1:0]       r_hit;
    logic [TW-1:0]       r_tid;
    logic                r_last;
    logic [CW-1:0]       r_cnt;
    logic                r_match;
    logic [TW-1:0]       r_cluster;
    logic                r_ovf;
    logic [EW-1:0]       r_epoch;
    logic [HW-1:0]       r_clr_addr;
    logic [CW-1:0]       r_wb_idx;
    logic                r_wb_pend;
    logic                r_out_valid;
    shtc_pkg::t_out_beat r_out;

    logic [HW-1:0]    in_hit;
    logic [TW-1:0]    in_tid;
    logic [CW-1:0]    eff_cnt;
    logic             buf_ok;
    logic             tbl_hit;
    logic             clr_last;
    logic             wb_more;
    logic             tbl_we;
    logic [HW-1:0]    tbl_waddr;
    shtc_pkg::t_entry tbl_wdata;
    logic             tbl_re;
    logic [HW-1:0]    tbl_raddr;

    assign in_hit   = HW'(shtc_pkg::reduce(i_in.hit_index, HIT_SPACE));
    assign in_tid   = TW'(shtc_pkg::reduce(XW'(i_in.track_id), MAX_TRACKS));
    assign eff_cnt  = i_in.start_of_event ? '0 : r_cnt;
    assign buf_ok   = (eff_cnt < CW'(MAX_HITS_PER_TRACK));
    assign tbl_hit  = (r_tbl_q.epoch == r_epoch);
    assign clr_last = (r_clr_addr == HW'(HIT_SPACE - 1));
    assign wb_more  = (r_wb_idx < r_cnt);

    assign tbl_we    = i_cmd.clear_step || r_wb_pend;
    assign tbl_waddr = i_cmd.clear_step ? r_clr_addr : r_buf_q;
    assign tbl_wdata = i_cmd.clear_step ? '0 : {r_epoch, r_tid};
    assign tbl_re    = i_cmd.accept || i_cmd.look;
    assign tbl_raddr = i_cmd.accept ? in_hit : r_hit;

    assign o_status.soe_wrap   = i_in.start_of_event && (&r_epoch);
    assign o_status.clear_last = clr_last;
    assign o_status.last       = r_last;
    assign o_status.match_now  = r_match || tbl_hit;
    assign o_status.wb_done    = !wb_more && !r_wb_pend;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            r_tbl_q <= r_tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && buf_ok) begin
            r_buf_mem[eff_cnt[BW-1:0]] <= in_hit;
        end
        if (i_cmd.wb_run && wb_more) begin
            r_buf_q <= r_buf_mem[r_wb_idx[BW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hit <= in_hit;
            r_tid <= in_tid;
        end
        if (i_cmd.emit) begin
            r_out.result_track  <= r_tid;
            r_out.cluster_id    <= r_match ? r_cluster : r_tid;
            r_out.new_cluster   <= !r_match;
            r_out.hits_overflow <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 1'b0;
            r_cnt       <= '0;
            r_match     <= 1'b0;
            r_cluster   <= '0;
            r_ovf       <= 1'b0;
            r_epoch     <= EW'(1);
            r_clr_addr  <= '0;
            r_wb_idx    <= '0;
            r_wb_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= i_in.last_hit;
                r_cnt  <= buf_ok ? eff_cnt + 1'b1 : eff_cnt;
                r_ovf  <= !i_in.start_of_event && (r_ovf || !buf_ok);
                if (i_in.start_of_event) begin
                    r_match   <= 1'b0;
                    r_cluster <= '0;
                    if (!(&r_epoch)) begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
                if (clr_last) begin
                    r_epoch <= EW'(1);
                end
            end
            if (i_cmd.check && !r_match && tbl_hit) begin
                r_match   <= 1'b1;
                r_cluster <= r_tbl_q.owner;
            end
            if (i_cmd.wb_start) begin
                r_wb_idx  <= '0;
                r_wb_pend <= 1'b0;
            end
            if (i_cmd.wb_run) begin
                if (wb_more) begin
                    r_wb_idx  <= r_wb_idx + 1'b1;
                    r_wb_pend <= 1'b1;
                end else begin
                    r_wb_pend <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_cnt       <= '0;
                r_match     <= 1'b0;
                r_cluster   <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("Result loaded over a beat that was not taken.");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_HITS_PER_TRACK))
        else $error("Buffered hit count exceeds the buffer depth.");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("Current epoch equals the cleared-entry mark.");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.check |-> $past(i_cmd.accept || i_cmd.look))
        else $error("Table entry checked without a preceding read.");

    a_wb_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_pend |-> !i_cmd.clear_step)
        else $error("Write-back collides with the clearing pass.");
`endif

endmodule
